@@ src/ssr_pkg.sv @@
// Shared constants, types and helpers for the stream substring replace block.
package ssr_pkg;

    localparam int MAX_PATTERN = 8;
    localparam int MAX_REPL    = 8;
    localparam int MAX_RES     = (MAX_PATTERN > MAX_REPL) ? MAX_PATTERN : MAX_REPL;
    localparam int OUT_DEPTH   = 2 * MAX_RES;
    localparam int FILL_W      = $clog2(MAX_PATTERN + 1);
    localparam int CNT_W       = $clog2(OUT_DEPTH + 1);
    localparam int SLOT_W      = $clog2(MAX_RES);
    localparam int LEN_W       = 4;
    localparam int BYTES_W     = 64;
    localparam int ADDR_W      = 5;

    typedef enum logic [1:0] {
        REG_PATTERN_BYTES      = 2'd0,
        REG_PATTERN_LENGTH     = 2'd1,
        REG_REPLACEMENT_BYTES  = 2'd2,
        REG_REPLACEMENT_LENGTH = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       end_of_line;
        logic       line_changed;
    } t_res;

    typedef struct packed {
        logic place;
        logic live;
        logic shift;
    } t_win_ctrl;

    typedef struct packed {
        logic              pop;
        logic              load;
        logic [SLOT_W-1:0] slot;
    } t_out_ctrl;

    // Pattern length as used: zero counts as one, large values saturate.
    function automatic logic [FILL_W-1:0] clamp_pattern_len(input logic [LEN_W-1:0] v);
        logic [FILL_W-1:0] r;
        if (v == '0) begin
            r = FILL_W'(1);
        end else if (32'(v) > MAX_PATTERN) begin
            r = FILL_W'(MAX_PATTERN);
        end else begin
            r = FILL_W'(v);
        end
        return r;
    endfunction

    function automatic logic [LEN_W-1:0] clamp_repl_len(input logic [LEN_W-1:0] v);
        logic [LEN_W-1:0] r;
        if (32'(v) > MAX_REPL) begin
            r = LEN_W'(MAX_REPL);
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

@@ src/ssr_if.sv @@
// Stream channel interfaces for line bytes in and rewritten results out.
interface ssr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] line_byte;
    logic       line_end;

    modport source (output valid, output line_byte, output line_end, input ready);
    modport sink   (input valid, input line_byte, input line_end, output ready);
endinterface

interface ssr_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       end_of_line;
    logic       line_changed;

    modport source (output valid, output out_byte, output byte_valid,
                    output end_of_line, output line_changed, input ready);
    modport sink   (input valid, input out_byte, input byte_valid,
                    input end_of_line, input line_changed, output ready);
endinterface

@@ src/ssr_win_cell.sv @@
// One window cell: holds a byte, takes the incoming byte or its neighbour's, compares.
module ssr_win_cell (
    input  logic               i_clk,
    input  logic               i_we,
    input  logic [7:0]         i_byte,
    input  logic [7:0]         i_pat,
    input  logic [7:0]         i_nbr,
    input  ssr_pkg::t_win_ctrl i_ctrl,
    output logic [7:0]         o_cur,
    output logic               o_eq
);

    logic [7:0] r_byte;
    logic [7:0] n_byte;

    // The incoming byte lands in the cell at the current fill position.
    assign o_cur  = i_ctrl.place ? i_byte : r_byte;
    assign o_eq   = !i_ctrl.live || (o_cur == i_pat);
    assign n_byte = i_ctrl.shift ? i_nbr : o_cur;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_byte <= n_byte;
        end
    end

endmodule

@@ src/ssr_out_cell.sv @@
// One result queue cell: shifts towards the head, or loads a fresh result.
module ssr_out_cell (
    input  logic               i_clk,
    input  ssr_pkg::t_res      i_new [ssr_pkg::MAX_RES],
    input  ssr_pkg::t_res      i_nbr,
    input  ssr_pkg::t_out_ctrl i_ctrl,
    output ssr_pkg::t_res      o_entry
);

    ssr_pkg::t_res r_entry;
    ssr_pkg::t_res n_entry;

    always_comb begin
        if (i_ctrl.load) begin
            n_entry = i_new[i_ctrl.slot];
        end else if (i_ctrl.pop) begin
            n_entry = i_nbr;
        end else begin
            n_entry = r_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule

@@ src/stream_substring_replace_core.sv @@
// Top level of the streaming substring replacement block.
//
//  Channel  Direction  Handshake      Carries
//  i_in     in         valid/ready    line_byte, line_end
//  o_out    out        valid/ready    out_byte, byte_valid, end_of_line, line_changed
//  APB      in/out     psel/penable   pattern and replacement registers, 64-bit data
//
// Each accepted byte is handled in the cycle of its transfer: it is placed in the
// window row, the row compares itself with the pattern cell by cell, and the zero to
// eight results it causes are loaded into a sixteen-entry result queue.
// The input is ready whenever the queue holds eight results or fewer, so a byte is
// taken every cycle while results flow; a replacement burst of r bytes adds r
// results to the queue and so can briefly stall the input.
// Reset clears the fill count, the changed flag, the queue count and the registers;
// window and queue contents carry no reset and there is no clearing pass.
module stream_substring_replace_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    ssr_in_if.sink                     i_in,
    ssr_out_if.source                  o_out,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [ssr_pkg::ADDR_W-1:0] paddr,
    input  logic [ssr_pkg::BYTES_W-1:0] pwdata,
    output logic [ssr_pkg::BYTES_W-1:0] prdata,
    output logic                       pready
);

    // Configuration registers.
    logic [ssr_pkg::BYTES_W-1:0] r_pat_bytes;
    logic [ssr_pkg::LEN_W-1:0]   r_pat_len;
    logic [ssr_pkg::BYTES_W-1:0] r_rep_bytes;
    logic [ssr_pkg::LEN_W-1:0]   r_rep_len;
    ssr_pkg::t_reg_idx           reg_idx;
    logic                        cfg_wr;

    assign pready  = 1'b1;
    assign reg_idx = ssr_pkg::t_reg_idx'(paddr[ssr_pkg::ADDR_W-1:3]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_bytes <= '0;
            r_pat_len   <= ssr_pkg::LEN_W'(1);
            r_rep_bytes <= '0;
            r_rep_len   <= '0;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                ssr_pkg::REG_PATTERN_BYTES:      r_pat_bytes <= pwdata;
                ssr_pkg::REG_PATTERN_LENGTH:     r_pat_len   <= pwdata[ssr_pkg::LEN_W-1:0];
                ssr_pkg::REG_REPLACEMENT_BYTES:  r_rep_bytes <= pwdata;
                ssr_pkg::REG_REPLACEMENT_LENGTH: r_rep_len   <= pwdata[ssr_pkg::LEN_W-1:0];
                default:                         r_pat_bytes <= r_pat_bytes;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            ssr_pkg::REG_PATTERN_BYTES:      prdata = r_pat_bytes;
            ssr_pkg::REG_PATTERN_LENGTH:
                prdata = ssr_pkg::BYTES_W'(r_pat_len);
            ssr_pkg::REG_REPLACEMENT_BYTES:  prdata = r_rep_bytes;
            ssr_pkg::REG_REPLACEMENT_LENGTH:
                prdata = ssr_pkg::BYTES_W'(r_rep_len);
            default:                         prdata = '0;
        endcase
    end

    // Window state: fill count, length in use and the line's changed flag.
    logic [ssr_pkg::FILL_W-1:0] r_fill;
    logic [ssr_pkg::FILL_W-1:0] n_fill;
    logic [ssr_pkg::FILL_W-1:0] r_len;
    logic                       r_changed;
    logic                       n_changed;
    logic [ssr_pkg::CNT_W-1:0]  r_cnt;
    logic [ssr_pkg::CNT_W-1:0]  n_cnt;

    logic                       acc;
    logic                       pop;
    logic [ssr_pkg::FILL_W-1:0] len;
    logic [ssr_pkg::FILL_W-1:0] fill_inc;
    logic                       full;
    logic                       match;
    logic                       shift;
    logic [ssr_pkg::LEN_W-1:0]  rep_len;
    logic [ssr_pkg::LEN_W-1:0]  res_n;
    logic                       line_chg;

    logic [7:0]                 win_cur [ssr_pkg::MAX_PATTERN];
    logic [ssr_pkg::MAX_PATTERN-1:0] win_eq;
    ssr_pkg::t_win_ctrl         win_ctrl [ssr_pkg::MAX_PATTERN];

    ssr_pkg::t_res              new_res [ssr_pkg::MAX_RES];
    ssr_pkg::t_res              q_entry [ssr_pkg::OUT_DEPTH];
    ssr_pkg::t_out_ctrl         q_ctrl  [ssr_pkg::OUT_DEPTH];
    logic [ssr_pkg::CNT_W-1:0]  q_base;

    // A new byte is taken while the queue has room for a worst-case burst.
    assign i_in.ready = (32'(r_cnt) <= ssr_pkg::MAX_RES);
    assign acc        = i_in.valid && i_in.ready;
    assign o_out.valid = (r_cnt != '0);
    assign pop        = o_out.valid && o_out.ready;

    // The pattern length is latched only when a fresh window starts.
    assign len      = (r_fill == '0) ? ssr_pkg::clamp_pattern_len(r_pat_len) : r_len;
    assign fill_inc = r_fill + ssr_pkg::FILL_W'(1);
    assign full     = (fill_inc >= len);
    assign match    = full && (&win_eq);
    assign shift    = full && !match;
    assign rep_len  = ssr_pkg::clamp_repl_len(r_rep_len);
    assign line_chg = r_changed || match;

    // The window row: each cell holds one byte and hands it down on a shift.
    for (genvar gi = 0; gi < ssr_pkg::MAX_PATTERN; gi++) begin : g_win
        logic [7:0] nbr;
        if (gi == ssr_pkg::MAX_PATTERN - 1) begin : g_last
            assign nbr = '0;
        end else begin : g_mid
            assign nbr = win_cur[gi+1];
        end

        assign win_ctrl[gi].place = (r_fill == ssr_pkg::FILL_W'(gi));
        assign win_ctrl[gi].live  = (ssr_pkg::FILL_W'(gi) < len);
        assign win_ctrl[gi].shift = shift;

        ssr_win_cell u_cell (
            .i_clk  (i_clk),
            .i_we   (acc),
            .i_byte (i_in.line_byte),
            .i_pat  (r_pat_bytes[8*gi +: 8]),
            .i_nbr  (nbr),
            .i_ctrl (win_ctrl[gi]),
            .o_cur  (win_cur[gi]),
            .o_eq   (win_eq[gi])
        );
    end

    // Results of this byte: either the replacement, or a run of window bytes
    // from the oldest onwards. A line end with nothing to emit gives a bare marker.
    always_comb begin
        if (match) begin
            res_n = rep_len;
        end else if (full) begin
            res_n = i_in.line_end ? ssr_pkg::LEN_W'(len) : ssr_pkg::LEN_W'(1);
        end else begin
            res_n = i_in.line_end ? ssr_pkg::LEN_W'(fill_inc) : '0;
        end
        if (i_in.line_end && res_n == '0) begin
            res_n = ssr_pkg::LEN_W'(1);
        end
    end

    always_comb begin
        for (int k = 0; k < ssr_pkg::MAX_RES; k++) begin
            if (match) begin
                new_res[k].out_byte   = r_rep_bytes[8*k +: 8];
                new_res[k].byte_valid = (rep_len != '0);
            end else if (k < ssr_pkg::MAX_PATTERN) begin
                new_res[k].out_byte   = win_cur[k];
                new_res[k].byte_valid = 1'b1;
            end else begin
                new_res[k].out_byte   = '0;
                new_res[k].byte_valid = 1'b0;
            end
            if (!new_res[k].byte_valid) begin
                new_res[k].out_byte = '0;
            end
            new_res[k].end_of_line  = i_in.line_end
                                      && (ssr_pkg::LEN_W'(k) == res_n - ssr_pkg::LEN_W'(1));
            new_res[k].line_changed = new_res[k].end_of_line && line_chg;
        end
    end

    // Window bookkeeping.
    always_comb begin
        n_fill    = r_fill;
        n_changed = r_changed;
        if (acc) begin
            if (i_in.line_end || match) begin
                n_fill = '0;
            end else if (full) begin
                n_fill = len - ssr_pkg::FILL_W'(1);
            end else begin
                n_fill = fill_inc;
            end
            if (i_in.line_end) begin
                n_changed = 1'b0;
            end else if (match) begin
                n_changed = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill    <= '0;
            r_len     <= ssr_pkg::FILL_W'(1);
            r_changed <= 1'b0;
        end else begin
            r_fill    <= n_fill;
            r_changed <= n_changed;
            if (acc) begin
                r_len <= len;
            end
        end
    end

    // Result queue: head in cell zero; new results land just behind what stays.
    assign q_base = r_cnt - ssr_pkg::CNT_W'(pop);
    assign n_cnt  = q_base + (acc ? ssr_pkg::CNT_W'(res_n) : '0);

    for (genvar gj = 0; gj < ssr_pkg::OUT_DEPTH; gj++) begin : g_out
        ssr_pkg::t_res             nbr;
        logic [ssr_pkg::CNT_W-1:0] gap;
        if (gj == ssr_pkg::OUT_DEPTH - 1) begin : g_last
            assign nbr = '0;
        end else begin : g_mid
            assign nbr = q_entry[gj+1];
        end

        assign gap               = ssr_pkg::CNT_W'(gj) - q_base;
        assign q_ctrl[gj].pop    = pop;
        assign q_ctrl[gj].load   = acc && (gap < ssr_pkg::CNT_W'(res_n));
        assign q_ctrl[gj].slot   = gap[ssr_pkg::SLOT_W-1:0];

        ssr_out_cell u_cell (
            .i_clk   (i_clk),
            .i_new   (new_res),
            .i_nbr   (nbr),
            .i_ctrl  (q_ctrl[gj]),
            .o_entry (q_entry[gj])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    assign o_out.out_byte     = q_entry[0].out_byte;
    assign o_out.byte_valid   = q_entry[0].byte_valid;
    assign o_out.end_of_line  = q_entry[0].end_of_line;
    assign o_out.line_changed = q_entry[0].line_changed;

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for the streaming substring replacement block.
module tb_top;
    import ssr_pkg::*;

    // The block handles a byte in the cycle of its transfer and queues the
    // results, so a short settling pause covers any work still in flight.
    localparam int SETTLE_CYCLES   = 16;
    localparam int RANDOM_ITEMS    = 450;
    // The receiver holds off once, for a long stretch, when this many bytes
    // have been offered; the sender keeps going so that the result queue fills.
    localparam int CHOKE_AT        = 140;
    localparam int CHOKE_CYCLES    = 300;
    // Neither side idles while the offered byte count lies in this range.
    localparam int QUIET_FROM      = 260;
    localparam int QUIET_TO        = 380;
    localparam int MAX_FAULT_LINES = 40;
    localparam int LIMIT_CYCLES    = 200000;

    // What the sender promised for one byte: either a result typed into the
    // opening table, or nothing, in which case the line model decides.
    typedef struct {
        logic typed;
        t_res want;
    } t_offer;

    // One row of the opening table: a register write or a line byte.
    typedef struct {
        logic       is_write;
        t_reg_idx   sel;
        logic [63:0] value;
        logic [7:0] line_byte;
        logic       line_end;
        logic       typed;
        t_res       want;
    } t_row;

    logic                i_clk;
    logic                i_rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [BYTES_W-1:0]  pwdata;
    logic [BYTES_W-1:0]  prdata;
    logic                pready;

    ssr_in_if  in_if ();
    ssr_out_if out_if ();

    stream_substring_replace_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Our own copy of the registers, updated at the edge that writes them.
    logic [63:0] cfg_pat_bytes;
    logic [3:0]  cfg_pat_len;
    logic [63:0] cfg_rep_bytes;
    logic [3:0]  cfg_rep_len;

    // Our own copy of the line state: the window, its fill, the length in
    // use for the current window and whether the line has seen a replacement.
    logic [7:0] win [8];
    int         win_fill;
    int         act_len;
    logic       line_hit;

    // Results of the latest byte, then the rewritten results still owed.
    t_res   step_res [16];
    int     step_n;
    t_res   rewritten_q [$];
    t_offer offered_q [$];
    t_row   opening_rows [$];

    int fault_count;
    int items_sent;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #(LIMIT_CYCLES * 10);
        $display("== FAIL ==");
        $finish;
    end

    function automatic t_res byte_res(input logic [7:0] b);
        return t_res'{b, 1'b1, 1'b0, 1'b0};
    endfunction

    // Pattern length as the block uses it: zero counts as one and anything
    // longer than the window saturates.
    function automatic int eff_pat_len();
        if (cfg_pat_len == 4'd0) begin
            return 1;
        end
        if (cfg_pat_len > 4'(MAX_PATTERN)) begin
            return MAX_PATTERN;
        end
        return int'(cfg_pat_len);
    endfunction

    // Advances the line state by one byte and leaves its results in step_res.
    function automatic void rewrite_step(input logic [7:0] b, input logic last);
        logic hit;
        int   rlen;
        int   i;
        step_n = 0;
        // The length in use is latched only when the window starts afresh.
        if (win_fill == 0) begin
            act_len = eff_pat_len();
        end
        win[win_fill] = b;
        win_fill++;
        if (win_fill >= act_len) begin
            hit = 1'b1;
            for (i = 0; i < act_len; i++) begin
                if (win[i] != cfg_pat_bytes[8*i +: 8]) begin
                    hit = 1'b0;
                end
            end
            if (hit) begin
                // Replacement bytes and length are read at the moment of use.
                rlen = (cfg_rep_len > 4'd8) ? 8 : int'(cfg_rep_len);
                for (i = 0; i < rlen; i++) begin
                    step_res[step_n] = byte_res(cfg_rep_bytes[8*i +: 8]);
                    step_n++;
                end
                win_fill = 0;
                line_hit = 1'b1;
            end else begin
                step_res[step_n] = byte_res(win[0]);
                step_n++;
                for (i = 1; i < win_fill; i++) begin
                    win[i-1] = win[i];
                end
                win_fill--;
            end
        end
        if (last) begin
            for (i = 0; i < win_fill; i++) begin
                step_res[step_n] = byte_res(win[i]);
                step_n++;
            end
            win_fill = 0;
            // With nothing left to emit, a bare end mark closes the line.
            if (step_n == 0) begin
                step_res[0] = '0;
                step_n = 1;
            end
            step_res[step_n-1].end_of_line  = 1'b1;
            step_res[step_n-1].line_changed = line_hit;
            line_hit = 1'b0;
        end
    endfunction

    task automatic flag_fault(input string what);
        if (fault_count < MAX_FAULT_LINES) begin
            $display("%0t: mismatch: %s", $time, what);
        end
        fault_count++;
    endtask

    // Both sides share this idling rule, with a quiet stretch in the middle.
    function automatic bit take_break();
        return (items_sent < QUIET_FROM || items_sent >= QUIET_TO) &&
               ($urandom_range(99) < 9);
    endfunction

    // A byte drawn mostly from the pattern itself, so that near misses and
    // overlapping partial matches turn up often.
    function automatic logic [7:0] pick_byte();
        int idx;
        idx = $urandom_range(eff_pat_len() - 1);
        if ($urandom_range(99) < 80) begin
            return cfg_pat_bytes[8*idx +: 8];
        end
        return 8'($urandom);
    endfunction

    // Offers one byte and returns in the time step of its transfer, leaving
    // valid high so that a following byte can go back to back.
    task automatic offer_byte(input logic [7:0] b, input logic last,
                              input logic typed, input t_res want);
        if (take_break()) begin
            in_if.valid <= 1'b0;
            do @(posedge i_clk); while (take_break());
        end
        offered_q.push_back('{typed, want});
        in_if.valid     <= 1'b1;
        in_if.line_byte <= b;
        in_if.line_end  <= last;
        items_sent++;
        do @(posedge i_clk); while (!in_if.ready);
    endtask

    // Idles the input until every owed result has been seen, then lets the
    // block settle before anything touches its registers.
    task automatic drain_results();
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (rewritten_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Setup cycle, then access cycle; the register takes the value at the
    // edge where the access completes. The task then waits with psel low so
    // that a second write never lowers and raises psel in the same time step.
    task automatic apb_write(input t_reg_idx sel, input logic [63:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({sel, 3'b000});
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (sel)
            REG_PATTERN_BYTES:      cfg_pat_bytes = value;
            REG_PATTERN_LENGTH:     cfg_pat_len   = value[3:0];
            REG_REPLACEMENT_BYTES:  cfg_rep_bytes = value;
            REG_REPLACEMENT_LENGTH: cfg_rep_len   = value[3:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    function automatic void add_write(input t_reg_idx sel, input logic [63:0] v);
        opening_rows.push_back('{1'b1, sel, v, 8'h00, 1'b0, 1'b0, t_res'('0)});
    endfunction

    function automatic void add_byte(input logic [7:0] b, input logic last);
        opening_rows.push_back('{1'b0, REG_PATTERN_BYTES, 64'd0, b, last, 1'b0,
                                 t_res'('0)});
    endfunction

    function automatic void add_typed(input logic [7:0] b, input logic last,
                                      input t_res want);
        opening_rows.push_back('{1'b0, REG_PATTERN_BYTES, 64'd0, b, last, 1'b1, want});
    endfunction

    // Builds one line of well-formed chunks (whole patterns, broken prefixes,
    // stray bytes), or now and then a line of pure noise, and sends it. With
    // close low the line is left open for the next phase to finish.
    task automatic send_line(input bit close);
        logic [7:0] line_q [$];
        int chunks;
        int kind;
        int plen;
        int cut;
        int j;
        int k;
        plen   = eff_pat_len();
        chunks = $urandom_range(1, 6);
        for (k = 0; k < chunks; k++) begin
            kind = $urandom_range(99);
            if (kind < 40) begin
                for (j = 0; j < plen; j++) begin
                    line_q.push_back(cfg_pat_bytes[8*j +: 8]);
                end
            end else if (kind < 60 && plen > 1) begin
                cut = $urandom_range(1, plen - 1);
                for (j = 0; j < cut; j++) begin
                    line_q.push_back(cfg_pat_bytes[8*j +: 8]);
                end
                line_q.push_back(pick_byte());
            end else if (kind < 90) begin
                line_q.push_back(pick_byte());
            end else begin
                line_q.push_back(8'($urandom));
            end
        end
        if ($urandom_range(99) < 10) begin
            line_q.delete();
            repeat ($urandom_range(1, 10)) line_q.push_back(8'($urandom));
        end
        for (k = 0; k < line_q.size(); k++) begin
            offer_byte(line_q[k], close && (k == line_q.size() - 1), 1'b0, t_res'('0));
        end
    endtask

    // Scoreboard. Each input transfer is run through the line model, or takes
    // the result typed into the table, and each output transfer is checked
    // field by field against the oldest result still owed.
    always @(posedge i_clk) begin : watch
        t_offer o;
        t_res   got;
        t_res   want;
        int     n;
        if (i_rst_n) begin
            if (in_if.valid && in_if.ready) begin
                o = offered_q.pop_front();
                rewrite_step(in_if.line_byte, in_if.line_end);
                if (o.typed) begin
                    rewritten_q.push_back(o.want);
                end else begin
                    for (n = 0; n < step_n; n++) begin
                        rewritten_q.push_back(step_res[n]);
                    end
                end
            end
            if (out_if.valid && out_if.ready) begin
                got = t_res'{out_if.out_byte, out_if.byte_valid,
                             out_if.end_of_line, out_if.line_changed};
                if (rewritten_q.size() == 0) begin
                    flag_fault($sformatf("result %h arrived with none owed", got));
                end else begin
                    want = rewritten_q.pop_front();
                    if (got.out_byte != want.out_byte) begin
                        flag_fault($sformatf("out_byte %h, wanted %h",
                                             got.out_byte, want.out_byte));
                    end
                    if (got.byte_valid != want.byte_valid) begin
                        flag_fault($sformatf("byte_valid %b, wanted %b",
                                             got.byte_valid, want.byte_valid));
                    end
                    if (got.end_of_line != want.end_of_line) begin
                        flag_fault($sformatf("end_of_line %b, wanted %b",
                                             got.end_of_line, want.end_of_line));
                    end
                    if (got.line_changed != want.line_changed) begin
                        flag_fault($sformatf("line_changed %b, wanted %b",
                                             got.line_changed, want.line_changed));
                    end
                end
            end
        end
    end

    // Receiver: random idling, plus one long hold-off counted here in cycles
    // while the sender keeps offering, so the block must stall its input.
    initial begin : receiver
        int  hold_left;
        bit  choked;
        hold_left = 0;
        choked    = 1'b0;
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                out_if.ready <= 1'b0;
                hold_left--;
            end else if (!choked && items_sent >= CHOKE_AT) begin
                choked    = 1'b1;
                hold_left = CHOKE_CYCLES - 1;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= !take_break();
            end
        end
    end

    initial begin : stimulus
        int          phase;
        int          phase_end;
        int          target;
        int          roll;
        int          idx;
        int          pl;
        int          rl;
        logic [7:0]  letter_a;
        logic [7:0]  letter_b;
        logic [63:0] pat;

        fault_count = 0;
        items_sent  = 0;
        cfg_pat_bytes = '0;
        cfg_pat_len   = 4'd1;
        cfg_rep_bytes = '0;
        cfg_rep_len   = 4'd0;
        win_fill = 0;
        act_len  = 1;
        line_hit = 1'b0;
        for (idx = 0; idx < 8; idx++) begin
            win[idx] = 8'h00;
        end

        i_rst_n         <= 1'b0;
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= '0;
        pwdata          <= '0;
        in_if.valid     <= 1'b0;
        in_if.line_byte <= 8'h00;
        in_if.line_end  <= 1'b0;

        // Straight after reset the pattern is a single zero byte and the
        // replacement is empty, so a lone zero is deleted and its line ends
        // with a bare end mark.
        add_typed(8'h41, 1'b0, byte_res(8'h41));
        add_typed(8'h00, 1'b1, t_res'{8'h00, 1'b0, 1'b1, 1'b1});
        add_typed(8'hFF, 1'b1, t_res'{8'hFF, 1'b1, 1'b1, 1'b0});
        // A zero pattern length acts as one; a replacement length beyond the
        // window saturates to a full eight-byte burst.
        add_write(REG_PATTERN_LENGTH, 64'd0);
        add_write(REG_PATTERN_BYTES, 64'hFFFF_FFFF_FFFF_FFFF);
        add_write(REG_REPLACEMENT_BYTES, 64'h8000_0000_0000_0001);
        add_write(REG_REPLACEMENT_LENGTH, 64'd15);
        add_byte(8'hFF, 1'b0);
        add_typed(8'h00, 1'b1, t_res'{8'h00, 1'b1, 1'b1, 1'b1});
        // An over-long pattern length saturates to eight; a full-window match
        // deleted at line end again leaves only the bare end mark.
        add_write(REG_PATTERN_LENGTH, 64'd15);
        add_write(REG_PATTERN_BYTES, 64'h0807_0605_0403_0201);
        add_write(REG_REPLACEMENT_LENGTH, 64'd0);
        for (idx = 1; idx < 8; idx++) begin
            add_byte(8'(idx), 1'b0);
        end
        add_typed(8'h08, 1'b1, t_res'{8'h00, 1'b0, 1'b1, 1'b1});
        // A short line flushes a window that never filled.
        add_byte(8'h01, 1'b0);
        add_byte(8'h02, 1'b0);
        add_byte(8'h03, 1'b1);
        // Registers rewritten with two bytes in the window: the new pattern
        // length waits for an empty window, the new replacement does not.
        add_byte(8'h01, 1'b0);
        add_byte(8'h02, 1'b0);
        add_write(REG_PATTERN_LENGTH, 64'd2);
        add_write(REG_REPLACEMENT_BYTES, 64'h0000_0000_0043_4241);
        add_write(REG_REPLACEMENT_LENGTH, 64'd3);
        for (idx = 3; idx < 8; idx++) begin
            add_byte(8'(idx), 1'b0);
        end
        add_byte(8'h08, 1'b1);
        add_byte(8'h01, 1'b0);
        add_byte(8'h02, 1'b1);

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (opening_rows[r]) begin
            if (opening_rows[r].is_write) begin
                if (r == 0 || !opening_rows[r-1].is_write) begin
                    drain_results();
                end
                apb_write(opening_rows[r].sel, opening_rows[r].value);
            end else begin
                offer_byte(opening_rows[r].line_byte, opening_rows[r].line_end,
                           opening_rows[r].typed, opening_rows[r].want);
            end
        end

        // Random phases: fresh registers, then a run of lines over a small
        // alphabet so that matches, overlaps and near misses are common.
        // The first two phases pin the extremes of both lengths.
        target = items_sent + RANDOM_ITEMS;
        for (phase = 0; items_sent < target; phase++) begin
            drain_results();
            if (phase == 0) begin
                pl = 8;
                rl = 8;
            end else if (phase == 1) begin
                pl = 1;
                rl = 0;
            end else begin
                roll = $urandom_range(99);
                if (roll < 10) begin
                    pl = 0;
                end else if (roll < 20) begin
                    pl = $urandom_range(9, 15);
                end else if (roll < 75) begin
                    pl = $urandom_range(1, 4);
                end else begin
                    pl = $urandom_range(5, 8);
                end
                roll = $urandom_range(99);
                if (roll < 15) begin
                    rl = 0;
                end else if (roll < 25) begin
                    rl = $urandom_range(9, 15);
                end else begin
                    rl = $urandom_range(1, 8);
                end
            end
            letter_a = 8'($urandom);
            letter_b = ($urandom_range(1) == 0) ? (letter_a ^ 8'h01) : 8'($urandom);
            pat = {$urandom, $urandom};
            for (idx = 0; idx < 8; idx++) begin
                if ($urandom_range(99) < 75) begin
                    pat[8*idx +: 8] = ($urandom_range(1) == 0) ? letter_a : letter_b;
                end
            end
            apb_write(REG_PATTERN_BYTES, pat);
            apb_write(REG_PATTERN_LENGTH, 64'(pl));
            apb_write(REG_REPLACEMENT_BYTES, {$urandom, $urandom});
            apb_write(REG_REPLACEMENT_LENGTH, 64'(rl));

            phase_end = items_sent + $urandom_range(20, 60);
            while (items_sent < phase_end) begin
                send_line(1'b1);
            end
            // Sometimes the phase stops inside a line, so that the next
            // register writes land on a part-filled window.
            if ($urandom_range(3) == 0) begin
                send_line(1'b0);
            end
        end
        offer_byte(pick_byte(), 1'b1, 1'b0, t_res'('0));

        drain_results();
        if (rewritten_q.size() != 0) begin
            flag_fault("results still owed at the end of the run");
        end
        if (fault_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

@@ files.f @@
src/ssr_pkg.sv
src/ssr_if.sv
src/ssr_win_cell.sv
src/ssr_out_cell.sv
src/stream_substring_replace_core.sv
tb/tb_top.sv
